// ===== rtl/tird_pkg.sv =====
// ============================================================================
// tird_pkg
// Types and constants shared by the tape image record deframer modules.
// ============================================================================
package tird_pkg;

  // Width of the max record length register
  localparam int unsigned CFG_LEN_W = 21;

  // Reset value of the max record length register
  localparam logic [CFG_LEN_W-1:0] MAX_LEN_RESET = 21'h100000;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_REC   = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;
  localparam logic [1:0] KIND_FATAL = 2'd3;

  // Fatal codes
  localparam logic [1:0] FATAL_NONE     = 2'd0;
  localparam logic [1:0] FATAL_TOO_LONG = 2'd1;
  localparam logic [1:0] FATAL_TRAILER  = 2'd2;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_HALT
  } phase_t;

  // One result item
  typedef struct packed {
    logic [1:0]           result_kind;
    logic [7:0]           data_out;
    logic [15:0]          record_number;
    logic [15:0]          file_number;
    logic [CFG_LEN_W-1:0] kept_length;
    logic                 checksum_present;
    logic                 lrc_error;
    logic                 length_suspect;
    logic                 empty_file;
    logic [1:0]           fatal_code;
  } tird_result_t;

endpackage

// ===== rtl/tird_if.sv =====
// ============================================================================
// tird channel interfaces
// Valid/ready channels for image bytes, results and the config write.
// ============================================================================

// Image byte channel
interface tird_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;

  modport source (output valid, output image_byte, input ready);
  modport sink   (input valid, input image_byte, output ready);
endinterface

// Result channel
interface tird_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  data_out;
  logic [15:0] record_number;
  logic [15:0] file_number;
  logic [20:0] kept_length;
  logic        checksum_present;
  logic        lrc_error;
  logic        length_suspect;
  logic        empty_file;
  logic [1:0]  fatal_code;

  modport source (
    output valid, input ready,
    output result_kind, output data_out, output record_number, output file_number,
    output kept_length, output checksum_present, output lrc_error,
    output length_suspect, output empty_file, output fatal_code
  );
  modport sink (
    input valid, output ready,
    input result_kind, input data_out, input record_number, input file_number,
    input kept_length, input checksum_present, input lrc_error,
    input length_suspect, input empty_file, input fatal_code
  );
endinterface

// Config write channel (max record length)
interface tird_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] max_record_length;

  modport source (output valid, output max_record_length, input ready);
  modport sink   (input valid, input max_record_length, output ready);
endinterface

// ===== rtl/tape_image_record_deframer_top.sv =====
// ============================================================================
// tape_image_record_deframer_top
// Splits a tape image byte stream into data bytes and per-record status.
// ============================================================================
//
//   channel  dir  payload                       transfer when
//   -------  ---  ----------------------------  ----------------------------
//   in_ch    in   image_byte                    in_ch.valid && in_ch.ready
//   out_ch   out  result_kind .. fatal_code     out_ch.valid && out_ch.ready
//   cfg_ch   in   max_record_length             cfg_ch.valid (ready tied high)
//
// One byte per cycle sustained while out_ch does not stall; the parser state
// updates as a byte moves from the input register to the result register.
// A byte passes the input register, then its result the result register, before out_ch.
// A stall on out_ch backs up through the input register; one byte is still
// taken while a finished result waits.
// Synchronous active-low reset; no clearing pass. Fatal errors halt until reset.
// ============================================================================
module tape_image_record_deframer_top import tird_pkg::*; #(
  parameter int unsigned LENGTH_BITS  = 21,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tird_in_if.sink    in_ch,
  tird_out_if.source out_ch,
  tird_cfg_if.sink   cfg_ch
);

  logic         can_load;
  logic         step;
  logic [7:0]   step_byte;
  logic         res_valid;
  tird_result_t res;
  tird_result_t out_res;
  logic         cfg_we;

  // Config register always writable
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  tird_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.image_byte),
    .can_load  (can_load),
    .step      (step),
    .step_byte (step_byte)
  );

  tird_core #(
    .LENGTH_BITS  (LENGTH_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_byte   (step_byte),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_ch.max_record_length),
    .res_valid (res_valid),
    .res       (res)
  );

  tird_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Result fields onto the channel
  assign out_ch.result_kind      = out_res.result_kind;
  assign out_ch.data_out         = out_res.data_out;
  assign out_ch.record_number    = out_res.record_number;
  assign out_ch.file_number      = out_res.file_number;
  assign out_ch.kept_length      = out_res.kept_length;
  assign out_ch.checksum_present = out_res.checksum_present;
  assign out_ch.lrc_error        = out_res.lrc_error;
  assign out_ch.length_suspect   = out_res.length_suspect;
  assign out_ch.empty_file       = out_res.empty_file;
  assign out_ch.fatal_code       = out_res.fatal_code;

endmodule

// ===== rtl/tird_in_reg.sv =====
// ============================================================================
// tird_in_reg
// Input register: holds one image byte until the parser can take it.
// ============================================================================
module tird_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       can_load,
  output logic       step,
  output logic [7:0] step_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // Byte moves on when the result register can take its outcome
  assign step      = valid_r && can_load;
  assign in_ready  = !valid_r || step;
  assign step_byte = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== rtl/tird_core.sv =====
// ============================================================================
// tird_core
// Record parser: header/payload/trailer tracking, checksum and length checks.
// ============================================================================
module tird_core import tird_pkg::*; #(
  parameter int unsigned LENGTH_BITS  = 21,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_we,
  input  logic [CFG_LEN_W-1:0] cfg_data,
  output logic                 res_valid,
  output tird_result_t         res
);

  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  // State
  phase_t                  phase_r, phase_nxt;
  logic [1:0]              fbc_r, fbc_nxt;
  logic [31:0]             hdr_r, hdr_nxt;
  logic [31:0]             trl_r, trl_nxt;
  logic [LENGTH_BITS-1:0]  pcount_r, pcount_nxt;
  logic [7:0]              lrc_r, lrc_nxt;
  logic [COUNTER_BITS-1:0] rec_cnt_r, rec_cnt_nxt;
  logic [COUNTER_BITS-1:0] file_cnt_r, file_cnt_nxt;
  logic [LENGTH_BITS-1:0]  exp_len_r, exp_len_nxt;
  logic                    csum_mode_r, csum_mode_nxt;
  logic                    rec_csum_r, rec_csum_nxt;
  logic                    suspect_r, suspect_nxt;
  logic [CFG_LEN_W-1:0]    max_len_r;

  // Shared intermediate values
  logic [31:0]             hdr_acc;
  logic [31:0]             trl_acc;
  logic [31:0]             limit;
  logic                    hdr_zero;
  logic                    hdr_over;
  logic [31:0]             hdr_m2;
  logic                    hdr_csum;
  logic                    hdr_suspect;
  logic [LENGTH_BITS-1:0]  pc_inc;
  logic                    pay_done;
  logic [LENGTH_BITS-1:0]  kept;
  logic                    trl_match;
  logic                    field_last;
  logic [COUNTER_BITS-1:0] rec_cnt_inc;
  logic [COUNTER_BITS-1:0] file_cnt_inc;

  // Byte lanes of the little-endian length fields
  assign hdr_acc    = hdr_r | (32'(in_byte) << {fbc_r, 3'b000});
  assign trl_acc    = trl_r | (32'(in_byte) << {fbc_r, 3'b000});
  assign field_last = (fbc_r == 2'd3);

  // Header checks
  assign limit    = (32'(max_len_r) < LEN_MASK) ? 32'(max_len_r) : LEN_MASK;
  assign hdr_zero = (hdr_acc == 32'd0);
  assign hdr_over = (hdr_acc > limit);
  assign hdr_m2   = hdr_acc - 32'd2;
  assign hdr_csum = ((hdr_m2 != 32'd0) && ((hdr_m2 & (hdr_m2 - 32'd1)) == 32'd0)) ||
                    csum_mode_r;

  always_comb begin
    hdr_suspect = 1'b0;
    if (rec_cnt_r != '0) begin
      if (hdr_csum) begin
        hdr_suspect = (hdr_acc < 32'd2) || (hdr_m2 != 32'(exp_len_r));
      end else begin
        hdr_suspect = (hdr_acc != 32'(exp_len_r));
      end
    end
  end

  // Payload progress and kept length (header is within LENGTH_BITS here)
  assign pc_inc   = pcount_r + LENGTH_BITS'(1);
  assign pay_done = (32'(pc_inc) >= hdr_r);

  always_comb begin
    kept = hdr_r[LENGTH_BITS-1:0];
    if (rec_csum_r) begin
      kept = (hdr_r >= 32'd2) ? hdr_r[LENGTH_BITS-1:0] - LENGTH_BITS'(2) : '0;
    end
  end

  assign trl_match    = (trl_acc == hdr_r);
  assign rec_cnt_inc  = (rec_cnt_r == CNT_MAX) ? rec_cnt_r : rec_cnt_r + COUNTER_BITS'(1);
  assign file_cnt_inc = (file_cnt_r == CNT_MAX) ? file_cnt_r :
                        file_cnt_r + COUNTER_BITS'(1);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (field_last && !hdr_zero) begin
          phase_nxt = hdr_over ? PH_HALT : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (pay_done) begin
          phase_nxt = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (field_last) begin
          phase_nxt = trl_match ? PH_HEADER : PH_HALT;
        end
      end
      PH_HALT:  phase_nxt = PH_HALT;
      default:  phase_nxt = PH_HALT;
    endcase
  end

  // Datapath updates and result
  always_comb begin
    fbc_nxt       = fbc_r;
    hdr_nxt       = hdr_r;
    trl_nxt       = trl_r;
    pcount_nxt    = pcount_r;
    lrc_nxt       = lrc_r;
    rec_cnt_nxt   = rec_cnt_r;
    file_cnt_nxt  = file_cnt_r;
    exp_len_nxt   = exp_len_r;
    csum_mode_nxt = csum_mode_r;
    rec_csum_nxt  = rec_csum_r;
    suspect_nxt   = suspect_r;

    res_valid         = 1'b0;
    res               = '0;
    res.record_number = 16'(rec_cnt_r);
    res.file_number   = 16'(file_cnt_r);

    case (phase_r)
      PH_HEADER: begin
        hdr_nxt = hdr_acc;
        fbc_nxt = fbc_r + 2'd1;
        if (field_last) begin
          if (hdr_zero) begin
            // file mark
            res_valid       = 1'b1;
            res.result_kind = KIND_MARK;
            res.empty_file  = (rec_cnt_r == '0);
            rec_cnt_nxt     = '0;
            exp_len_nxt     = '0;
            csum_mode_nxt   = 1'b0;
          end else if (hdr_over) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_FATAL;
            res.fatal_code  = FATAL_TOO_LONG;
          end else begin
            rec_csum_nxt = hdr_csum;
            suspect_nxt  = hdr_suspect;
            if (rec_cnt_r == '0) begin
              file_cnt_nxt = file_cnt_inc;
            end
            pcount_nxt = '0;
            lrc_nxt    = 8'd0;
            trl_nxt    = 32'd0;
          end
        end
      end
      PH_PAYLOAD: begin
        lrc_nxt    = lrc_r ^ in_byte;
        pcount_nxt = pc_inc;
        if (pcount_r < kept) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_DATA;
          res.data_out    = in_byte;
        end
      end
      PH_TRAILER: begin
        trl_nxt = trl_acc;
        fbc_nxt = fbc_r + 2'd1;
        if (field_last) begin
          res_valid = 1'b1;
          if (!trl_match) begin
            res.result_kind = KIND_FATAL;
            res.fatal_code  = FATAL_TRAILER;
          end else begin
            res.result_kind      = KIND_REC;
            res.kept_length      = CFG_LEN_W'(kept);
            res.checksum_present = rec_csum_r;
            res.lrc_error        = rec_csum_r && (lrc_r != 8'd0);
            res.length_suspect   = suspect_r;
            if ((rec_cnt_r == '0) && (lrc_r == 8'd0)) begin
              csum_mode_nxt = 1'b1;
            end
            if (exp_len_r == '0) begin
              exp_len_nxt = kept;
            end
            rec_cnt_nxt = rec_cnt_inc;
            hdr_nxt     = 32'd0;
          end
        end
      end
      PH_HALT: begin
        // bytes are swallowed
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      fbc_r       <= 2'd0;
      hdr_r       <= 32'd0;
      trl_r       <= 32'd0;
      pcount_r    <= '0;
      lrc_r       <= 8'd0;
      rec_cnt_r   <= '0;
      file_cnt_r  <= '0;
      exp_len_r   <= '0;
      csum_mode_r <= 1'b0;
      rec_csum_r  <= 1'b0;
      suspect_r   <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      fbc_r       <= fbc_nxt;
      hdr_r       <= hdr_nxt;
      trl_r       <= trl_nxt;
      pcount_r    <= pcount_nxt;
      lrc_r       <= lrc_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      file_cnt_r  <= file_cnt_nxt;
      exp_len_r   <= exp_len_nxt;
      csum_mode_r <= csum_mode_nxt;
      rec_csum_r  <= rec_csum_nxt;
      suspect_r   <= suspect_nxt;
    end
  end

  // Max record length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_data;
    end
  end

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("halt phase left without reset");

  // Nothing comes out once halted
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_HALT) |-> !res_valid)
    else $error("result produced while halted");

  // Data bytes come only from the payload phase
  a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.result_kind == KIND_DATA) |-> phase_r == PH_PAYLOAD)
    else $error("data byte outside payload");

  // Field byte count is only in use inside length fields
  a_fbc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    fbc_r != 2'd0 |-> (phase_r == PH_HEADER || phase_r == PH_TRAILER))
    else $error("field byte count set outside length fields");

  // Entering halt always comes with a fatal result
  a_halt_fatal: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r != PH_HALT && phase_nxt == PH_HALT) |->
      (res_valid && res.result_kind == KIND_FATAL))
    else $error("halt without fatal result");

endmodule

// ===== rtl/tird_out_reg.sv =====
// ============================================================================
// tird_out_reg
// Result register: holds one result until the downstream side takes it.
// ============================================================================
module tird_out_reg import tird_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic         res_valid,
  input  tird_result_t res,
  output logic         can_load,
  output logic         out_valid,
  input  logic         out_ready,
  output tird_result_t out_res
);

  logic         valid_r;
  logic         valid_nxt;
  tird_result_t res_r;

  // Free, or being emptied this cycle
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== dv/tird_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tird_checker
// Watches the image byte, result and config channels of the tape image
// record deframer. Each image byte transfer runs through a local deframer
// model whose predicted results queue up in order. Each result transfer is
// compared field by field with the oldest prediction.
// ============================================================================
module tird_checker import tird_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tird_in_if          in_ch,
  tird_out_if         out_ch,
  tird_cfg_if         cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned data_seen,
  output int unsigned records_seen,
  output int unsigned marks_seen,
  output int unsigned fatals_seen
);

  // Deframer model state
  phase_t               parse_phase;
  logic [1:0]           field_idx;
  logic [31:0]          hdr_len;
  logic [31:0]          trl_len;
  logic [CFG_LEN_W-1:0] pay_cnt;
  logic [7:0]           lrc_acc;
  logic [15:0]          rec_cnt;
  logic [15:0]          file_cnt;
  logic [CFG_LEN_W-1:0] exp_len;
  logic                 lrc_mode;
  logic                 rec_chk;
  logic                 rec_len_bad;
  logic [CFG_LEN_W-1:0] len_limit;

  // Predicted results, oldest first
  tird_result_t deframed_q[$];

  function automatic bit is_pow2(input logic [31:0] v);
    return v != 32'd0 && (v & (v - 32'd1)) == 32'd0;
  endfunction

  // Counters stick at all ones
  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Payload bytes kept once a trailing checksum is stripped
  function automatic logic [31:0] kept_len();
    if (!rec_chk)
      return hdr_len;
    return (hdr_len >= 32'd2) ? hdr_len - 32'd2 : 32'd0;
  endfunction

  // Result skeleton carrying the current counters
  function automatic tird_result_t stamp(input logic [1:0] kind);
    tird_result_t r;
    r               = '0;
    r.result_kind   = kind;
    r.record_number = rec_cnt;
    r.file_number   = file_cnt;
    return r;
  endfunction

  task automatic reset_model();
    parse_phase = PH_HEADER;
    field_idx   = 2'd0;
    hdr_len     = 32'd0;
    trl_len     = 32'd0;
    pay_cnt     = '0;
    lrc_acc     = 8'd0;
    rec_cnt     = 16'd0;
    file_cnt    = 16'd0;
    exp_len     = '0;
    lrc_mode    = 1'b0;
    rec_chk     = 1'b0;
    rec_len_bad = 1'b0;
    len_limit   = MAX_LEN_RESET;
    deframed_q.delete();
  endtask

  // Advance the model by one image byte, queueing any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    tird_result_t r;
    logic [31:0]  kept;
    case (parse_phase)
      PH_HEADER: begin
        hdr_len = hdr_len | ({24'd0, b} << (8 * field_idx));
        if (field_idx < 2'd3) begin
          field_idx = field_idx + 2'd1;
        end else begin
          field_idx = 2'd0;
          if (hdr_len == 32'd0) begin
            // file mark
            r            = stamp(KIND_MARK);
            r.empty_file = (rec_cnt == 16'd0);
            deframed_q.push_back(r);
            rec_cnt  = 16'd0;
            exp_len  = '0;
            lrc_mode = 1'b0;
          end else if (hdr_len > {11'd0, len_limit}) begin
            parse_phase  = PH_HALT;
            r            = stamp(KIND_FATAL);
            r.fatal_code = FATAL_TOO_LONG;
            deframed_q.push_back(r);
          end else begin
            rec_chk     = is_pow2(hdr_len - 32'd2) || lrc_mode;
            rec_len_bad = 1'b0;
            if (rec_cnt != 16'd0) begin
              if (rec_chk)
                rec_len_bad = hdr_len < 32'd2 || (hdr_len - 32'd2) != {11'd0, exp_len};
              else
                rec_len_bad = hdr_len != {11'd0, exp_len};
            end
            if (rec_cnt == 16'd0)
              file_cnt = bump(file_cnt);
            pay_cnt     = '0;
            lrc_acc     = 8'd0;
            trl_len     = 32'd0;
            parse_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        lrc_acc = lrc_acc ^ b;
        if ({11'd0, pay_cnt} < kept_len()) begin
          r          = stamp(KIND_DATA);
          r.data_out = b;
          deframed_q.push_back(r);
        end
        pay_cnt = pay_cnt + CFG_LEN_W'(1);
        if ({11'd0, pay_cnt} >= hdr_len)
          parse_phase = PH_TRAILER;
      end
      PH_TRAILER: begin
        trl_len = trl_len | ({24'd0, b} << (8 * field_idx));
        if (field_idx < 2'd3) begin
          field_idx = field_idx + 2'd1;
        end else begin
          field_idx = 2'd0;
          if (trl_len != hdr_len) begin
            parse_phase  = PH_HALT;
            r            = stamp(KIND_FATAL);
            r.fatal_code = FATAL_TRAILER;
            deframed_q.push_back(r);
          end else begin
            kept               = kept_len();
            r                  = stamp(KIND_REC);
            r.kept_length      = kept[CFG_LEN_W-1:0];
            r.checksum_present = rec_chk;
            r.lrc_error        = rec_chk && lrc_acc != 8'd0;
            r.length_suspect   = rec_len_bad;
            deframed_q.push_back(r);
            // a zero-LRC first record puts the rest of the file in checksum mode
            if (rec_cnt == 16'd0 && lrc_acc == 8'd0)
              lrc_mode = 1'b1;
            if (exp_len == '0)
              exp_len = kept[CFG_LEN_W-1:0];
            rec_cnt     = bump(rec_cnt);
            parse_phase = PH_HEADER;
            hdr_len     = 32'd0;
          end
        end
      end
      default: ; // halted: bytes are dropped until reset
    endcase
  endtask

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    fail_count++;
    $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h",
             $time, what, got, want);
  endtask

  task automatic cmp_field(input string what, input logic [31:0] got,
                           input logic [31:0] want);
    if (got !== want)
      log_mismatch(what, got, want);
  endtask

  // Compare one result transfer with the oldest prediction
  task automatic check_result();
    tird_result_t got;
    tird_result_t want;
    got = {out_ch.result_kind, out_ch.data_out, out_ch.record_number,
           out_ch.file_number, out_ch.kept_length, out_ch.checksum_present,
           out_ch.lrc_error, out_ch.length_suspect, out_ch.empty_file,
           out_ch.fatal_code};
    case (got.result_kind)
      KIND_DATA:  data_seen++;
      KIND_REC:   records_seen++;
      KIND_MARK:  marks_seen++;
      KIND_FATAL: fatals_seen++;
      default: ;
    endcase
    if (deframed_q.size() == 0) begin
      log_mismatch("unexpected result, kind", 32'(got.result_kind), 32'd0);
      return;
    end
    want = deframed_q.pop_front();
    cmp_field("result_kind",      32'(got.result_kind),      32'(want.result_kind));
    cmp_field("data_out",         32'(got.data_out),         32'(want.data_out));
    cmp_field("record_number",    32'(got.record_number),    32'(want.record_number));
    cmp_field("file_number",      32'(got.file_number),      32'(want.file_number));
    cmp_field("kept_length",      32'(got.kept_length),      32'(want.kept_length));
    cmp_field("checksum_present", 32'(got.checksum_present), 32'(want.checksum_present));
    cmp_field("lrc_error",        32'(got.lrc_error),        32'(want.lrc_error));
    cmp_field("length_suspect",   32'(got.length_suspect),   32'(want.length_suspect));
    cmp_field("empty_file",       32'(got.empty_file),       32'(want.empty_file));
    cmp_field("fatal_code",       32'(got.fatal_code),       32'(want.fatal_code));
  endtask

  // Results are checked before the same edge's byte is modeled, so a result
  // can never match a prediction made at its own edge
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      fail_count   = 0;
      data_seen    = 0;
      records_seen = 0;
      marks_seen   = 0;
      fatals_seen  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        check_result();
      if (cfg_ch.valid && cfg_ch.ready)
        len_limit = cfg_ch.max_record_length;
      if (in_ch.valid && in_ch.ready)
        deframe_byte(in_ch.image_byte);
    end
    pending = deframed_q.size();
  end

endmodule

// ===== dv/tape_image_record_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tape_image_record_deframer_top_tb
// Feeds framed tape image records, file marks and one final corrupt frame
// into the deframer under several max record length settings, with random
// gaps and stalls on both channels; tird_checker predicts and compares.
// ============================================================================
module tape_image_record_deframer_top_tb;
  import tird_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned HOLD_AT_BYTE = 200;
  localparam int unsigned HOLD_CYCLES  = 80;

  logic clk = 1'b0;
  logic rst_n;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_in;
  int unsigned limit_now;
  int unsigned mid_limit;
  int unsigned cycle_count;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned n_data;
  int unsigned n_rec;
  int unsigned n_mark;
  int unsigned n_fatal;

  tird_in_if  in_ch ();
  tird_out_if out_ch ();
  tird_cfg_if cfg_ch ();

  tape_image_record_deframer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tird_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending_results),
    .data_seen    (n_data),
    .records_seen (n_rec),
    .marks_seen   (n_mark),
    .fatals_seen  (n_fatal)
  );

  always #5 clk = ~clk;

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result receiver: random stalls plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // One image byte transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.image_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_in++;
    @(negedge clk);
  endtask

  // Little-endian length word; a zero word is a file mark
  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++)
      send_byte(w[8*i +: 8]);
  endtask

  // Header, payload and matching trailer; zero_xor forces a zero LRC
  task automatic send_record(input int unsigned len, input bit zero_xor);
    logic [7:0] lrc;
    logic [7:0] d;
    lrc = 8'd0;
    send_word(len);
    for (int unsigned i = 0; i < len; i++) begin
      d = 8'($urandom);
      if (zero_xor && i == len - 1)
        d = lrc;
      lrc = lrc ^ d;
      send_byte(d);
    end
    send_word(len);
  endtask

  // Random files: repeated lengths, checksum-sized lengths, short records
  task automatic send_files(input int unsigned budget);
    int unsigned start;
    int unsigned len;
    int unsigned prev;
    int unsigned pick;
    start = bytes_in;
    prev  = 0;
    while (bytes_in - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_word(32'd0);
        prev = 0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30 && prev != 0)
          len = prev;
        else if (pick < 50)
          len = (1 << $urandom_range(0, 6)) + 2;
        else if (pick < 62)
          len = $urandom_range(1, 3);
        else
          len = $urandom_range(1, 24);
        if (len > limit_now)
          len = $urandom_range(1, limit_now);
        send_record(len, $urandom_range(0, 2) == 0);
        prev = len;
      end
    end
  endtask

  // Let every predicted result drain, then the pipeline settle
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input int unsigned v);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.max_record_length <= v[CFG_LEN_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    limit_now = v;
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned len;
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.image_byte         = 8'd0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.max_record_length = '0;
    bytes_in                 = 0;
    limit_now                = 32'(MAX_LEN_RESET);
    send_gap_pct             = 7;
    recv_stall_pct           = 45;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // mark on an empty file
    send_word(32'd0);
    // 3-byte record, checksum by length, zero LRC: file enters checksum mode
    send_word(32'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_word(32'd3);
    // 1-byte record under checksum mode keeps nothing and is suspect
    send_word(32'd1);
    send_byte(8'h80);
    send_word(32'd1);
    // mark closing a non-empty file
    send_word(32'd0);

    send_files(180);
    wait_quiet();

    // smallest limit: only one-byte records and marks fit
    write_limit(1);
    send_files(60);
    send_record(1, 1'b1);
    send_record(1, 1'b0);
    send_word(32'd0);
    wait_quiet();

    // largest limit, gaps and stalls swapped
    send_gap_pct   = 45;
    recv_stall_pct = 7;
    write_limit(2097151);
    send_record(258, 1'b0);
    send_files(180);
    wait_quiet();

    // mid-range limit, no idling; a record exactly at the limit
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    mid_limit      = $urandom_range(16, 200);
    write_limit(mid_limit);
    send_record(limit_now, 1'b0);
    send_files(180);

    // one corrupt frame halts the block; later bytes are dropped
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 1) == 0)
        send_word(limit_now + 1);
      else
        send_word($urandom | 32'h8000_0000);
    end else begin
      len = $urandom_range(1, 8);
      send_word(len);
      for (int unsigned i = 0; i < len; i++)
        send_byte(8'($urandom));
      send_word(len ^ (32'd1 << $urandom_range(0, 31)));
    end
    for (int i = 0; i < 16; i++)
      send_byte(8'($urandom));
    wait_quiet();

    $display("covered %0d image bytes: %0d data bytes, %0d record ends, %0d file marks,",
             bytes_in, n_data, n_rec, n_mark);
    $display("%0d fatal stop, record length limits 1048576, 1, 2097151 and %0d",
             n_fatal, mid_limit);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== tape_image_record_deframer_top.f =====
rtl/tird_pkg.sv
rtl/tird_if.sv
rtl/tird_in_reg.sv
rtl/tird_core.sv
rtl/tird_out_reg.sv
rtl/tape_image_record_deframer_top.sv
dv/tird_checker.sv
dv/tape_image_record_deframer_top_tb.sv
